// ===== hw/rtl/qpe_pkg.sv =====
// Shared types, character codes and helpers for the quoted-printable encoder.
`timescale 1ns / 1ps

package qpe_pkg;

  localparam int QPE_MAX_CHARS   = 7;
  localparam int QPE_QUEUE_DEPTH = 2;
  localparam int QPE_LIMIT_W     = 7;
  localparam int QPE_COL_W       = 8;
  localparam int QPE_CNT_W       = 3;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQUALS = 8'h3D;

  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_PRINTABLE_LIMIT = 2'd0;
  localparam logic [1:0] REG_SPACE_LIMIT     = 2'd1;
  localparam logic [1:0] REG_ESCAPE_LIMIT    = 2'd2;

  localparam logic [QPE_LIMIT_W-1:0] PRINTABLE_LIMIT_RST = 7'd76;
  localparam logic [QPE_LIMIT_W-1:0] SPACE_LIMIT_RST     = 7'd70;
  localparam logic [QPE_LIMIT_W-1:0] ESCAPE_LIMIT_RST    = 7'd73;

  // Width of an escape sequence in output columns.
  localparam logic [QPE_COL_W-1:0] ESCAPE_COLS = 8'd3;

  typedef struct packed {
    logic [QPE_LIMIT_W-1:0] printable_limit;
    logic [QPE_LIMIT_W-1:0] space_limit;
    logic [QPE_LIMIT_W-1:0] escape_limit;
  } qpe_limits_t;

  // One queued job: the characters for one input byte, first one in
  // the lowest slot, and how many of them are meaningful.
  typedef struct packed {
    logic [QPE_MAX_CHARS-1:0][7:0] chars;
    logic [QPE_CNT_W-1:0]          count;
  } qpe_job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'd0, nib};
    end else begin
      res = 8'h37 + {4'd0, nib};
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/qpe_front.sv =====
// Front end: accepts raw bytes, tracks the column and builds the character job.
`timescale 1ns / 1ps

module qpe_front (
  input  logic               clk,
  input  logic               rst_n,
  input  qpe_pkg::qpe_limits_t limits,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               q_full,
  output logic               q_push,
  output qpe_pkg::qpe_job_t  q_job
);
  import qpe_pkg::*;

  logic [QPE_COL_W-1:0] column_r;
  logic [QPE_COL_W-1:0] column_nxt;
  logic [QPE_COL_W-1:0] col_inc;
  logic [QPE_COL_W-1:0] col_pre;
  logic [QPE_COL_W-1:0] col_esc;
  logic                 is_print;
  logic                 pre_brk;
  logic                 post_brk;
  logic [7:0]           hex_hi;
  logic [7:0]           hex_lo;
  qpe_job_t             job;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign q_job     = job;

  assign is_print = (in_tdata inside {[CH_PRINT_LO:CH_PRINT_HI]}) && (in_tdata != CH_EQUALS);
  assign col_inc  = column_r + 8'd1;
  assign pre_brk  = column_r > {1'b0, limits.escape_limit};
  assign col_pre  = pre_brk ? '0 : column_r;
  assign col_esc  = col_pre + ESCAPE_COLS;
  assign hex_hi   = hex_char(in_tdata[7:4]);
  assign hex_lo   = hex_char(in_tdata[3:0]);

  always_comb begin
    job        = '0;
    post_brk   = 1'b0;
    column_nxt = column_r;
    if (is_print) begin
      post_brk      = col_inc > {1'b0, limits.printable_limit};
      job.chars[0]  = in_tdata;
      job.chars[1]  = CH_LF;
      job.count     = post_brk ? 3'd2 : 3'd1;
      column_nxt    = post_brk ? '0 : col_inc;
    end else if (in_tdata == CH_SPACE) begin
      post_brk      = col_inc > {1'b0, limits.space_limit};
      job.chars[0]  = in_tdata;
      job.chars[1]  = CH_EQUALS;
      job.chars[2]  = CH_LF;
      job.count     = post_brk ? 3'd3 : 3'd1;
      column_nxt    = post_brk ? '0 : col_inc;
    end else if (in_tdata == CH_LF) begin
      job.chars[0]  = CH_LF;
      job.count     = 3'd1;
      column_nxt    = '0;
    end else begin
      post_brk = col_esc > {1'b0, limits.escape_limit};
      if (pre_brk) begin
        job.chars[0] = CH_EQUALS;
        job.chars[1] = CH_LF;
        job.chars[2] = CH_EQUALS;
        job.chars[3] = hex_hi;
        job.chars[4] = hex_lo;
        job.chars[5] = CH_EQUALS;
        job.chars[6] = CH_LF;
      end else begin
        job.chars[0] = CH_EQUALS;
        job.chars[1] = hex_hi;
        job.chars[2] = hex_lo;
        job.chars[3] = CH_EQUALS;
        job.chars[4] = CH_LF;
      end
      job.count  = 3'd3 + (pre_brk ? 3'd2 : 3'd0) + (post_brk ? 3'd2 : 3'd0);
      column_nxt = post_brk ? '0 : col_esc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
    end else if (q_push) begin
      column_r <= column_nxt;
    end
  end

endmodule

// ===== hw/rtl/qpe_queue.sv =====
// Small job queue between the front end and the character serialiser.
`timescale 1ns / 1ps

module qpe_queue #(
  parameter int DEPTH = qpe_pkg::QPE_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qpe_pkg::qpe_job_t push_job,
  input  logic              pop,
  output qpe_pkg::qpe_job_t head_job,
  output logic              full,
  output logic              empty
);
  import qpe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  qpe_job_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = fill_r == FULL_CNT;
  assign empty    = fill_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/qpe_back.sv =====
// Back end: shifts one job's characters out, one beat per cycle unless stalled.
`timescale 1ns / 1ps

module qpe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  qpe_pkg::qpe_job_t head_job,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);
  import qpe_pkg::*;

  logic [QPE_MAX_CHARS-1:0][7:0] chars_r;
  logic [QPE_MAX_CHARS-1:0][7:0] chars_nxt;
  logic [QPE_CNT_W-1:0]          left_r;
  logic [QPE_CNT_W-1:0]          left_nxt;
  logic                          take_next;

  assign out_tvalid = left_r != '0;
  assign out_tdata  = chars_r[0];
  assign out_tlast  = left_r == 3'd1;

  // A new job is taken when the register is empty or its final beat leaves now.
  assign take_next = !out_tvalid || (out_tready && out_tlast);
  assign q_pop     = take_next && !q_empty;

  always_comb begin
    chars_nxt = chars_r;
    left_nxt  = left_r;
    if (take_next) begin
      if (!q_empty) begin
        chars_nxt = head_job.chars;
        left_nxt  = head_job.count;
      end else begin
        left_nxt  = '0;
      end
    end else if (out_tready) begin
      chars_nxt = {8'h00, chars_r[QPE_MAX_CHARS-1:1]};
      left_nxt  = left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
  end

endmodule

// ===== hw/rtl/quoted_printable_encoder_core.sv =====
// Top level of the quoted-printable encoder: register bank and datapath wiring.
`timescale 1ns / 1ps

// Quoted-printable encoder.
// Input channel in_*: one raw byte per beat on in_tdata. Output channel out_*:
// one encoded ASCII character per beat on out_tdata, with out_tlast marking
// the final character produced for an input byte (one to seven characters).
// The three line limits sit on the cfg_* port at byte addresses 0, 4 and 8
// and should be written only while no byte is in flight.
// When the output side is free, an input byte is written into the job queue
// and then loaded into the output register, which presents its first character.
// The front end takes a byte every cycle while the job queue has room; the
// output register gives one character per cycle while out_tready is high.
// A byte produces one character for plain text, two for text with a hard
// line feed, three for a space with a soft break and three to seven for
// escapes.
// A stall on out_tready holds the current character; the queue then fills
// and in_tready drops until room returns.
// Reset clears the column, empties the queue and the output register and
// restores the default limits.
module quoted_printable_encoder_core #(
  parameter int QUEUE_DEPTH = qpe_pkg::QPE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import qpe_pkg::*;

  logic [QPE_LIMIT_W-1:0] plim_r;
  logic [QPE_LIMIT_W-1:0] slim_r;
  logic [QPE_LIMIT_W-1:0] elim_r;
  logic                   cfg_wr;
  logic [1:0]             reg_idx;
  qpe_limits_t            limits;
  qpe_job_t               push_job;
  qpe_job_t               head_job;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plim_r <= PRINTABLE_LIMIT_RST;
      slim_r <= SPACE_LIMIT_RST;
      elim_r <= ESCAPE_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PRINTABLE_LIMIT: plim_r <= cfg_pwdata[QPE_LIMIT_W-1:0];
        REG_SPACE_LIMIT:     slim_r <= cfg_pwdata[QPE_LIMIT_W-1:0];
        REG_ESCAPE_LIMIT:    elim_r <= cfg_pwdata[QPE_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PRINTABLE_LIMIT: cfg_prdata = {25'd0, plim_r};
      REG_SPACE_LIMIT:     cfg_prdata = {25'd0, slim_r};
      REG_ESCAPE_LIMIT:    cfg_prdata = {25'd0, elim_r};
      default:             cfg_prdata = '0;
    endcase
  end

  assign limits.printable_limit = plim_r;
  assign limits.space_limit     = slim_r;
  assign limits.escape_limit    = elim_r;

  qpe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .limits    (limits),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  qpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  qpe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/qpe_checker.sv =====
// Port-level checks for the quoted-printable encoder, bound to the top level.
`timescale 1ns / 1ps

module qpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       cfg_pready
);
  import qpe_pkg::*;

  // A held beat keeps its character and its end marker.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // Nothing is presented in the cycle after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  // An escape or a soft break never ends on its equals sign.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata != CH_EQUALS)
    else $error("byte finished on an equals sign");

  // After a reset cycle the configuration port is always ready.
  assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind quoted_printable_encoder_core qpe_checker u_qpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

// ===== bench/qpe_stream_checker.sv =====
// Checker for the quoted-printable encoder: predicts every encoded character and compares.
`timescale 1ns / 1ps

module qpe_stream_checker
  import qpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] in_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,    // [7:0] out_byte
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending_count,
  output int          chars_checked
);

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  enc_char_t            expected_chars[$];
  logic [QPE_COL_W-1:0] line_col;
  qpe_limits_t          limits;
  int                   fails = 0;
  int                   checked = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    chars_checked = 0;
  end

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) return ASCII_ZERO + 8'(nib);
    return ASCII_UPPER_A + 8'(nib) - 8'd10;
  endfunction

  // Works out the characters one raw byte turns into and queues them.
  task automatic encode_byte(input logic [7:0] raw);
    logic [7:0] seq[$];
    enc_char_t  item;
    if (raw >= CH_PRINT_LO && raw <= CH_PRINT_HI && raw != CH_EQUALS) begin
      seq.push_back(raw);
      line_col = line_col + 8'd1;
      if (line_col > limits.printable_limit) begin
        seq.push_back(CH_LF);
        line_col = '0;
      end
    end else if (raw == CH_SPACE) begin
      seq.push_back(raw);
      line_col = line_col + 8'd1;
      if (line_col > limits.space_limit) begin
        seq.push_back(CH_EQUALS);
        seq.push_back(CH_LF);
        line_col = '0;
      end
    end else if (raw == CH_LF) begin
      seq.push_back(CH_LF);
      line_col = '0;
    end else begin
      // An escape may need a soft break both before and after it.
      if (line_col > limits.escape_limit) begin
        seq.push_back(CH_EQUALS);
        seq.push_back(CH_LF);
        line_col = '0;
      end
      seq.push_back(CH_EQUALS);
      seq.push_back(hex_digit(raw[7:4]));
      seq.push_back(hex_digit(raw[3:0]));
      line_col = line_col + ESCAPE_COLS;
      if (line_col > limits.escape_limit) begin
        seq.push_back(CH_EQUALS);
        seq.push_back(CH_LF);
        line_col = '0;
      end
    end
    foreach (seq[i]) begin
      item.ch   = seq[i];
      item.last = (i == seq.size() - 1);
      expected_chars.push_back(item);
    end
  endtask

  always @(posedge clk) begin
    enc_char_t want;
    if (!rst_n) begin
      expected_chars.delete();
      line_col               = '0;
      limits.printable_limit = PRINTABLE_LIMIT_RST;
      limits.space_limit     = SPACE_LIMIT_RST;
      limits.escape_limit    = ESCAPE_LIMIT_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_chars.size() == 0) begin
          $error("out beat with nothing expected: out_byte=%02h last=%0b", out_tdata, out_tlast);
          fails++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== want.ch) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.ch, out_tdata);
            fails++;
          end
          if (out_tlast !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_tlast);
            fails++;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_PRINTABLE_LIMIT: limits.printable_limit = cfg_pwdata[QPE_LIMIT_W-1:0];
          REG_SPACE_LIMIT:     limits.space_limit     = cfg_pwdata[QPE_LIMIT_W-1:0];
          REG_ESCAPE_LIMIT:    limits.escape_limit    = cfg_pwdata[QPE_LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        encode_byte(in_tdata);
      end
    end
    fail_count    <= fails;
    pending_count <= expected_chars.size();
    chars_checked <= checked;
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the encoder testbench: clock, reset, stimulus, back-pressure and the verdict.
`timescale 1ns / 1ps

module testbench;
  import qpe_pkg::*;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 4;
  localparam logic [1:0] REG_UNUSED   = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] out_byte
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int   fail_count;
  int   pending_count;
  int   chars_checked;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  int   settings_used = 1;
  int   stall_left = 0;
  logic steady = 1'b0;   // no idling on either side while set

  logic [7:0] edge_bytes[13] = '{8'h00, 8'hFF, 8'h20, 8'h0A, 8'h3D, 8'h7F, 8'h21,
                                 8'h7E, 8'h80, 8'h1F, 8'h41, 8'h09, 8'h0D};
  logic [7:0] zero_limit_bytes[5] = '{8'h41, 8'h20, 8'h00, 8'h0A, 8'hAB};

  quoted_printable_encoder_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  qpe_stream_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .chars_checked (chars_checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sender_gap();
    if (steady || $urandom_range(0, 99) < 45) return 0;
    return idle_length();
  endfunction

  // Mostly text with spaces and line feeds, so that columns build up and breaks occur.
  function automatic logic [7:0] text_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    if (pick < 60) return CH_SPACE;
    if (pick < 66) return CH_LF;
    if (pick < 72) return CH_EQUALS;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver back-pressure: out_tready drops for random stretches.
  always @(posedge clk) begin
    if (!steady && stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 25) begin
        stall_left <= idle_length();
      end
    end
  end

  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = sender_gap();
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves psel high so that back-to-back writes follow each other without an idle phase.
  task automatic apb_write(input logic [1:0] index, input logic [6:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= ($urandom() & 32'hFFFF_FF80) | 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic program_limits(input logic [6:0] printable, input logic [6:0] space,
                                input logic [6:0] escape, input bit poke_unused);
    wait_drained();
    apb_write(REG_PRINTABLE_LIMIT, printable);
    apb_write(REG_SPACE_LIMIT, space);
    apb_write(REG_ESCAPE_LIMIT, escape);
    if (poke_unused) begin
      apb_write(REG_UNUSED, 7'($urandom_range(0, 127)));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic send_text(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) begin
        wait_drained();
      end
      send_byte(text_byte());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (edge_bytes[i]) send_byte(edge_bytes[i]);

    // With every limit at zero each class of byte breaks straight away.
    program_limits(7'd0, 7'd0, 7'd0, 1'b1);
    foreach (zero_limit_bytes[i]) send_byte(zero_limit_bytes[i]);

    program_limits(7'd127, 7'd127, 7'd127, 1'b0);
    send_text(50, 1'b1);

    // Lowered limits while the column is still high from the previous phase.
    steady <= 1'b1;
    program_limits(7'd10, 7'd5, 7'd8, 1'b0);
    send_text(30, 1'b0);
    steady <= 1'b0;

    program_limits(7'd1, 7'd2, 7'd1, 1'b0);
    send_text(25, 1'b0);

    program_limits(PRINTABLE_LIMIT_RST, SPACE_LIMIT_RST, ESCAPE_LIMIT_RST, 1'b0);
    send_text(40, 1'b0);

    program_limits(7'($urandom_range(1, 127)), 7'($urandom_range(1, 127)),
                   7'($urandom_range(1, 127)), 1'b1);
    send_text(25, 1'b0);

    program_limits(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)), 1'b0);
    send_text(25, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Encoded %0d input bytes under %0d limit settings, zero and maximum limits included.",
             bytes_sent, settings_used);
    $display("%0d output characters were compared with their prediction.", chars_checked);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped by the cycle limit after %0d cycles.", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
